// ===== rtl/adcssd_pkg.sv =====
// Package with shared types, constants and the sample-to-segment table of the voltmeter display.
package adcssd_pkg;

	localparam int FULL_SCALE = 250;
	localparam int DIGIT_COUNT = 3;
	localparam logic [7:0] SAMPLE_PERIOD_RESET = 8'd50;
	localparam logic [7:0] DECIMAL_POINT = 8'h80;

	typedef enum logic {
		OP_TICK   = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		POS_FIRST  = 2'd1,
		POS_SECOND = 2'd2,
		POS_THIRD  = 2'd3
	} scan_pos_t;

	typedef logic [DIGIT_COUNT-1:0][7:0] digit_codes_t;
	typedef logic [255:0][DIGIT_COUNT*8-1:0] sample_table_t;

	typedef struct packed {
		logic [7:0] segment_pattern;
		logic [2:0] digit_enable;
		logic       sample_request;
	} scan_result_t;

	function automatic logic [7:0] seg_code(input int digit);
		logic [7:0] code;
		case (digit)
			0: code = 8'h3F;
			1: code = 8'h06;
			2: code = 8'h5B;
			3: code = 8'h4F;
			4: code = 8'h66;
			5: code = 8'h6D;
			6: code = 8'h7D;
			7: code = 8'h07;
			8: code = 8'h7F;
			9: code = 8'h6F;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

	// Each entry holds the three digit codes for one raw reading, first digit in the low byte.
	function automatic sample_table_t build_sample_table();
		sample_table_t tbl;
		int scaled;
		int hund;
		int tens;
		int units;
		for (int r = 0; r < 256; r++) begin
			scaled = (r * FULL_SCALE) / 255;
			hund = scaled / 100;
			tens = (scaled / 10) % 10;
			units = scaled % 10;
			if (hund > 9) begin
				hund = 9;
			end
			tbl[r[7:0]] = {seg_code(units), seg_code(tens), seg_code(hund) | DECIMAL_POINT};
		end
		return tbl;
	endfunction

	localparam sample_table_t SAMPLE_TABLE = build_sample_table();

endpackage

// ===== rtl/adcssd_if.sv =====
// Valid/ready channel interfaces for the input items and the display results.
interface adcssd_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] sample_value;

	modport source (output valid, output opcode, output sample_value, input ready);
	modport sink (input valid, input opcode, input sample_value, output ready);
endinterface

interface adcssd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] segment_pattern;
	logic [2:0] digit_enable;
	logic       sample_request;

	modport source (output valid, output segment_pattern, output digit_enable,
		output sample_request, input ready);
	modport sink (input valid, input segment_pattern, input digit_enable,
		input sample_request, output ready);
endinterface

// ===== rtl/adcssd_digit_store.sv =====
// Digit code registers loaded from the sample-to-segment table.
module adcssd_digit_store
	import adcssd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic [7:0]   sample_value,
	output digit_codes_t digit_codes
);

	digit_codes_t codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q <= '0;
		end else if (load) begin
			codes_q <= SAMPLE_TABLE[sample_value];
		end
	end

	assign digit_codes = codes_q;

endmodule

// ===== rtl/adcssd_scan.sv =====
// Digit scan sequencer and tick counter that raises the sample request.
module adcssd_scan
	import adcssd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         tick,
	input  logic [7:0]   sample_period,
	input  digit_codes_t digit_codes,
	output scan_result_t result
);

	scan_pos_t  pos_q;
	scan_pos_t  pos_next;
	logic [7:0] count_q;
	logic [7:0] count_inc;
	logic       request;

	always_comb begin
		case (pos_q)
			POS_SECOND: begin
				result.segment_pattern = digit_codes[1];
				result.digit_enable = 3'b010;
				pos_next = POS_FIRST;
			end
			POS_FIRST: begin
				result.segment_pattern = digit_codes[0];
				result.digit_enable = 3'b001;
				pos_next = POS_THIRD;
			end
			default: begin
				result.segment_pattern = digit_codes[2];
				result.digit_enable = 3'b100;
				pos_next = POS_SECOND;
			end
		endcase
		count_inc = count_q + 8'd1;
		request = (count_inc >= sample_period);
		result.sample_request = request;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_THIRD;
			count_q <= '0;
		end else if (tick) begin
			pos_q <= pos_next;
			count_q <= request ? 8'd0 : count_inc;
		end
	end

endmodule

// ===== rtl/adc_reading_seven_segment_display_unit.sv =====
// Top level of the three-digit multiplexed seven-segment voltmeter display.
// An input transaction is either a converter sample, which updates the three stored digit codes
// and returns nothing, or a scan tick, which returns the segment byte and one-hot enable of the
// next digit (third, second, first) and a sample request flag. One transaction is accepted every
// clock cycle while no tick is held by a stalled output; a tick result reaches the output
// channel through the input register and the result register that enclose the single pass of decode logic.
// The sample period register resets to 50 and should be written only while the block is idle.
module adc_reading_seven_segment_display_unit
	import adcssd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	adcssd_in_if.sink           in_ch,
	adcssd_out_if.source        out_ch,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);

	logic         valid_s1;
	opcode_t      opcode_s1;
	logic [7:0]   sample_s1;
	logic         valid_s2;
	scan_result_t result_s2;
	logic [7:0]   period_q;
	logic         out_free;
	logic         advance;
	logic         tick_go;
	logic         sample_go;
	digit_codes_t digit_codes;
	scan_result_t scan_result;

	assign out_free = !valid_s2 || out_ch.ready;
	assign advance = valid_s1 && ((opcode_s1 == OP_SAMPLE) || out_free);
	assign tick_go = advance && (opcode_s1 == OP_TICK);
	assign sample_go = advance && (opcode_s1 == OP_SAMPLE);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= SAMPLE_PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			opcode_s1 <= opcode_t'(in_ch.opcode);
			sample_s1 <= in_ch.sample_value;
		end
	end

	adcssd_digit_store u_digit_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (sample_go),
		.sample_value (sample_s1),
		.digit_codes  (digit_codes)
	);

	adcssd_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (tick_go),
		.sample_period (period_q),
		.digit_codes   (digit_codes),
		.result        (scan_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= tick_go;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			result_s2 <= scan_result;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.segment_pattern = result_s2.segment_pattern;
	assign out_ch.digit_enable = result_s2.digit_enable;
	assign out_ch.sample_request = result_s2.sample_request;

endmodule

// ===== tb/adc_reading_seven_segment_display_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the voltmeter display: directed and random transactions with a predictor.
module adc_reading_seven_segment_display_unit_tb;
	import adcssd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_ITEMS = 150;
	localparam int PHASE_COUNT = 9;
	localparam logic [2:0] EN_FIRST = 3'b001;
	localparam logic [2:0] EN_SECOND = 3'b010;
	localparam logic [2:0] EN_THIRD = 3'b100;
	localparam logic [7:0] SEG_DIGITS [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	adcssd_in_if in_ch ();
	adcssd_out_if out_ch ();

	adc_reading_seven_segment_display_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic [7:0] disp_codes [3];
	scan_pos_t disp_pos;
	logic [7:0] disp_ticks;
	logic [7:0] disp_period;
	scan_result_t pending_scans [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit no_idle = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void reset_display();
		disp_codes[0] = '0;
		disp_codes[1] = '0;
		disp_codes[2] = '0;
		disp_pos = POS_THIRD;
		disp_ticks = '0;
		disp_period = SAMPLE_PERIOD_RESET;
	endfunction

	function automatic void load_reading(input logic [7:0] raw);
		int scaled;
		int hund;
		int tens;
		int units;
		scaled = (int'(raw) * FULL_SCALE) / 255;
		hund = scaled / 100;
		tens = (scaled / 10) % 10;
		units = scaled % 10;
		if (hund > 9) begin
			hund = 9;
		end
		disp_codes[0] = SEG_DIGITS[hund[3:0]] | DECIMAL_POINT;
		disp_codes[1] = SEG_DIGITS[tens[3:0]];
		disp_codes[2] = SEG_DIGITS[units[3:0]];
	endfunction

	function automatic void advance_scan();
		scan_result_t res;
		case (disp_pos)
			POS_SECOND: begin
				res.segment_pattern = disp_codes[1];
				res.digit_enable = EN_SECOND;
				disp_pos = POS_FIRST;
			end
			POS_FIRST: begin
				res.segment_pattern = disp_codes[0];
				res.digit_enable = EN_FIRST;
				disp_pos = POS_THIRD;
			end
			default: begin
				res.segment_pattern = disp_codes[2];
				res.digit_enable = EN_THIRD;
				disp_pos = POS_SECOND;
			end
		endcase
		disp_ticks = disp_ticks + 8'd1;
		res.sample_request = 1'b0;
		if (disp_ticks >= disp_period) begin
			disp_ticks = '0;
			res.sample_request = 1'b1;
		end
		pending_scans.push_back(res);
	endfunction

	function automatic int idle_gap();
		int roll;
		if (no_idle) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end
		if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("ERROR at %0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
		mismatch_count++;
	endtask

	task automatic send_item(input opcode_t op, input logic [7:0] value);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.sample_value <= value;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (op == OP_SAMPLE) begin
			load_reading(value);
		end else begin
			advance_scan();
		end
	endtask

	task automatic drain_display();
		in_ch.valid <= 1'b0;
		while (pending_scans.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_period(input logic [7:0] value);
		drain_display();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		disp_period = value;
	endtask

	task automatic test_blank_after_reset();
		repeat (3) send_item(OP_TICK, 8'h00);
	endtask

	task automatic test_reading_extremes();
		send_item(OP_SAMPLE, 8'h00);
		repeat (3) send_item(OP_TICK, 8'hFF);
		send_item(OP_SAMPLE, 8'hFF);
		repeat (3) send_item(OP_TICK, 8'h00);
		// Back-to-back samples: only the last one should be displayed.
		send_item(OP_SAMPLE, 8'h55);
		send_item(OP_SAMPLE, 8'hAA);
		repeat (3) send_item(OP_TICK, 8'h55);
	endtask

	task automatic test_period_edges();
		// A zero period requests a sample on every tick.
		write_period(8'd0);
		repeat (2) send_item(OP_TICK, 8'h00);
		write_period(8'd1);
		send_item(OP_TICK, 8'h00);
		write_period(8'd255);
		repeat (4) send_item(OP_TICK, 8'h00);
		// The period drops below the running count, so the next tick must wrap it.
		write_period(8'd2);
		send_item(OP_TICK, 8'h00);
	endtask

	task automatic test_random_traffic();
		logic [7:0] periods [PHASE_COUNT];
		logic [7:0] value;
		periods = '{8'd50, 8'd1, 8'd255, 8'd3, 8'd0, 8'd2, 8'd9, 8'd0, 8'd128};
		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (periods[p[3:0]] == 8'd0) begin
				periods[p[3:0]] = 8'($urandom_range(4, 40));
			end
			write_period(periods[p[3:0]]);
			no_idle = (p == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 5 && i == PHASE_ITEMS / 2) begin
					drain_display();
				end
				if ($urandom_range(0, 99) < 70) begin
					send_item(OP_TICK, 8'($urandom));
				end else begin
					value = 8'($urandom);
					if ($urandom_range(0, 9) == 0) begin
						value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					end
					send_item(OP_SAMPLE, value);
				end
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int stall;
		scan_result_t want;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (pending_scans.size() == 0) begin
					report_mismatch("unexpected transaction, segment_pattern", 0,
						int'(out_ch.segment_pattern));
				end else begin
					want = pending_scans.pop_front();
					if (out_ch.segment_pattern !== want.segment_pattern) begin
						report_mismatch("segment_pattern", int'(want.segment_pattern),
							int'(out_ch.segment_pattern));
					end
					if (out_ch.digit_enable !== want.digit_enable) begin
						report_mismatch("digit_enable", int'(want.digit_enable),
							int'(out_ch.digit_enable));
					end
					if (out_ch.sample_request !== want.sample_request) begin
						report_mismatch("sample_request", int'(want.sample_request),
							int'(out_ch.sample_request));
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				stall = idle_gap();
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_TICK;
		in_ch.sample_value = '0;
		out_ch.ready = 1'b0;
		reset_display();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_blank_after_reset();
		test_reading_extremes();
		test_period_edges();
		test_random_traffic();
		drain_display();
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/adcssd_pkg.sv
rtl/adcssd_if.sv
rtl/adcssd_digit_store.sv
rtl/adcssd_scan.sv
rtl/adc_reading_seven_segment_display_unit.sv
tb/adc_reading_seven_segment_display_unit_tb.sv
